### hw/rtl/btlv_pkg.sv
// ----------------------------------------------------------------------------
// BER TLV header parser package
// Shared types, codes and field widths for the BER TLV header parser.
// ----------------------------------------------------------------------------
package btlv_pkg;

  localparam int unsigned MaxLengthBytes = 8;
  localparam int unsigned TagW           = 64;
  localparam int unsigned LenW           = 64;
  localparam int unsigned ByteW          = 8;
  localparam int unsigned OutDataW       = 144;  // 141 field bits padded to bytes

  localparam logic [4:0] HighTagMark = 5'b11111;

  // Event kinds, carried on the master tuser
  typedef enum logic [1:0] {
    EV_HEADER  = 2'd0,
    EV_CONTENT = 2'd1,
    EV_ERROR   = 2'd2
  } event_kind_e;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_INDEFINITE = 2'd1,
    ERR_LEN_BYTES  = 2'd2,
    ERR_TRUNCATED  = 2'd3
  } error_code_e;

  // One-hot parse phases
  typedef enum logic [5:0] {
    PH_IDLE = 6'b000001,
    PH_TAGX = 6'b000010,
    PH_LEN0 = 6'b000100,
    PH_LENL = 6'b001000,
    PH_DATA = 6'b010000,
    PH_DROP = 6'b100000
  } phase_e;

  // One result item between the decoder and the output stage
  typedef struct packed {
    logic             valid;
    event_kind_e      kind;
    logic [1:0]       tag_class;
    logic             is_constructed;
    logic [TagW-1:0]  tag_number;
    logic [LenW-1:0]  content_length;
    logic [ByteW-1:0] content_byte;
    logic             last_content;
    error_code_e      error_code;
  } event_t;

endpackage

### hw/rtl/ber_tlv_header_parser_top.sv
// ----------------------------------------------------------------------------
// BER TLV header parser, top level
// Each result is registered in the output register, or in the skid entry.
// Throughput: one byte per cycle while the skid entry is free.
// Two result slots (output register and skid entry) absorb a stalled sink.
// Reset: rst_ni clears the parse phase to awaiting identifier and empties
// the output slots; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ber_tlv_header_parser_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Slave side: one byte of the BER buffer per transaction
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,  // [7:0] in_byte
  input  logic                                s_axis_tlast,  // end_of_buffer
  // Master side: header, content byte or error event
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [1:0] tag_class, [2] is_constructed, [66:3] tag_number,
  // [130:67] content_length, [138:131] content_byte, [140:139] error_code,
  // [143:141] zero
  output logic [btlv_pkg::OutDataW-1:0]       m_axis_tdata,
  output logic [1:0]                          m_axis_tuser,  // [1:0] event_kind
  output logic                                m_axis_tlast   // last_content
);
  import btlv_pkg::*;

  logic   space;
  logic   accept;
  event_t ev;

  // Take a byte whenever the skid entry is free; the output register may
  // still hold an unread result at that time.
  assign s_axis_tready = space;
  assign accept        = s_axis_tvalid && space;

  // Decode the byte against the held parse state and form at most one event
  btlv_decoder u_decoder (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .in_byte_i       (s_axis_tdata),
    .end_of_buffer_i (s_axis_tlast),
    .event_o         (ev)
  );

  // Hold the event until the sink takes it
  btlv_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .event_i       (ev),
    .space_o       (space),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

### hw/rtl/btlv_decoder.sv
// ----------------------------------------------------------------------------
// BER TLV decoder core
// Parse state registers and the combinational next-state and event logic.
// ----------------------------------------------------------------------------
module btlv_decoder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic [btlv_pkg::ByteW-1:0]     in_byte_i,
  input  logic                           end_of_buffer_i,
  output btlv_pkg::event_t               event_o
);
  import btlv_pkg::*;

  phase_e            phase_q, phase_d;
  logic [1:0]        class_q, class_d;
  logic              cons_q, cons_d;
  logic [TagW-1:0]   tag_q, tag_d;
  logic [3:0]        left_q, left_d;
  logic [LenW-1:0]   lacc_q, lacc_d;
  logic [LenW-1:0]   cleft_q, cleft_d;

  logic              do_err;
  error_code_e       err_code;
  logic              do_hdr;
  logic [LenW-1:0]   hdr_len;
  logic [3:0]        left_dec;
  logic [LenW-1:0]   lacc_shift;
  event_t            ev;

  assign left_dec   = left_q - 4'd1;
  assign lacc_shift = {lacc_q[LenW-ByteW-1:0], in_byte_i};

  always_comb begin
    phase_d  = phase_q;
    class_d  = class_q;
    cons_d   = cons_q;
    tag_d    = tag_q;
    left_d   = left_q;
    lacc_d   = lacc_q;
    cleft_d  = cleft_q;
    do_err   = 1'b0;
    err_code = ERR_NONE;
    do_hdr   = 1'b0;
    hdr_len  = '0;
    ev       = '0;

    case (phase_q)
      PH_IDLE: begin
        class_d = in_byte_i[7:6];
        cons_d  = in_byte_i[5];
        if (in_byte_i[4:0] == HighTagMark) begin
          tag_d   = '0;
          phase_d = PH_TAGX;
        end else begin
          tag_d   = {{(TagW-5){1'b0}}, in_byte_i[4:0]};
          phase_d = PH_LEN0;
        end
        if (end_of_buffer_i) begin
          do_err   = 1'b1;
          err_code = ERR_TRUNCATED;
        end
      end
      PH_TAGX: begin
        tag_d = {tag_q[TagW-8:0], in_byte_i[6:0]};
        if (!in_byte_i[7]) phase_d = PH_LEN0;
        if (end_of_buffer_i) begin
          do_err   = 1'b1;
          err_code = ERR_TRUNCATED;
        end
      end
      PH_LEN0: begin
        if (!in_byte_i[7]) begin
          do_hdr  = 1'b1;
          hdr_len = {{(LenW-ByteW){1'b0}}, in_byte_i};
        end else if (in_byte_i[6:0] == 7'd0) begin
          do_err   = 1'b1;
          err_code = ERR_INDEFINITE;
        end else if (in_byte_i[6:0] > 7'(MaxLengthBytes)) begin
          do_err   = 1'b1;
          err_code = ERR_LEN_BYTES;
        end else begin
          left_d  = in_byte_i[3:0];
          lacc_d  = '0;
          phase_d = PH_LENL;
          if (end_of_buffer_i) begin
            do_err   = 1'b1;
            err_code = ERR_TRUNCATED;
          end
        end
      end
      PH_LENL: begin
        lacc_d = lacc_shift;
        left_d = left_dec;
        if (left_dec == 4'd0) begin
          do_hdr  = 1'b1;
          hdr_len = lacc_shift;
        end else if (end_of_buffer_i) begin
          do_err   = 1'b1;
          err_code = ERR_TRUNCATED;
        end
      end
      PH_DATA: begin
        if (end_of_buffer_i && (cleft_q > LenW'(1))) begin
          do_err   = 1'b1;
          err_code = ERR_TRUNCATED;
        end else begin
          ev.valid        = 1'b1;
          ev.kind         = EV_CONTENT;
          ev.content_byte = in_byte_i;
          if (cleft_q <= LenW'(1)) begin
            ev.last_content = 1'b1;
            cleft_d         = '0;
            phase_d         = PH_IDLE;
          end else begin
            cleft_d = cleft_q - LenW'(1);
          end
        end
      end
      default: begin
        // Drop bytes until the end of the buffer
        if (end_of_buffer_i) phase_d = PH_IDLE;
      end
    endcase

    // A header ending on the final byte with content still to come is truncated
    if (do_hdr) begin
      if (end_of_buffer_i && (hdr_len != '0)) begin
        do_err   = 1'b1;
        err_code = ERR_TRUNCATED;
      end else begin
        ev.valid          = 1'b1;
        ev.kind           = EV_HEADER;
        ev.tag_class      = class_q;
        ev.is_constructed = cons_q;
        ev.tag_number     = tag_d;
        ev.content_length = hdr_len;
        if (!cons_q && (hdr_len != '0)) begin
          cleft_d = hdr_len;
          phase_d = PH_DATA;
        end else begin
          phase_d = PH_IDLE;
        end
      end
    end

    if (do_err) begin
      ev            = '0;
      ev.valid      = 1'b1;
      ev.kind       = EV_ERROR;
      ev.error_code = err_code;
      phase_d       = end_of_buffer_i ? PH_IDLE : PH_DROP;
    end

    if (!accept_i) ev.valid = 1'b0;
  end

  assign event_o = ev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
    end else if (accept_i) begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_q <= '0;
      cons_q  <= 1'b0;
      tag_q   <= '0;
      left_q  <= '0;
      lacc_q  <= '0;
      cleft_q <= '0;
    end else if (accept_i) begin
      class_q <= class_d;
      cons_q  <= cons_d;
      tag_q   <= tag_d;
      left_q  <= left_d;
      lacc_q  <= lacc_d;
      cleft_q <= cleft_d;
    end
  end

endmodule

### hw/rtl/btlv_out_stage.sv
// ----------------------------------------------------------------------------
// BER TLV output stage
// Output register plus one skid entry; keeps the input ready registered.
// ----------------------------------------------------------------------------
module btlv_out_stage (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  btlv_pkg::event_t                    event_i,
  output logic                                space_o,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [btlv_pkg::OutDataW-1:0]       m_axis_tdata,
  output logic [1:0]                          m_axis_tuser,
  output logic                                m_axis_tlast
);
  import btlv_pkg::*;

  logic   out_valid_q, skid_valid_q;
  event_t out_q, skid_q;
  logic   pop;

  assign pop     = out_valid_q && m_axis_tready;
  assign space_o = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) skid_valid_q <= 1'b0;
    end else if (event_i.valid) begin
      if (out_valid_q && !pop) skid_valid_q <= 1'b1;
      else                     out_valid_q  <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) out_q <= skid_q;
    end else if (event_i.valid) begin
      if (out_valid_q && !pop) skid_q <= event_i;
      else                     out_q  <= event_i;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last_content;
  assign m_axis_tdata  = {3'b000, out_q.error_code, out_q.content_byte,
                          out_q.content_length, out_q.tag_number,
                          out_q.is_constructed, out_q.tag_class};

endmodule

### hw/rtl/btlv_checker.sv
// ----------------------------------------------------------------------------
// BER TLV parser port checker
// Port-level assertions on the parser top level, attached by bind.
// ----------------------------------------------------------------------------
module btlv_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tready,
  input  logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic [btlv_pkg::OutDataW-1:0]       m_axis_tdata,
  input  logic [1:0]                          m_axis_tuser,
  input  logic                                m_axis_tlast
);
  import btlv_pkg::*;

  // Hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // Backpressure only while a result is waiting
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result pending");

  // Last marker only on content bytes
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == EV_CONTENT)
    else $error("tlast on a non-content event");

  // Error events carry a code, others none
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tuser == EV_ERROR) == (m_axis_tdata[140:139] != ERR_NONE)))
    else $error("error code does not match event kind");

  // A byte on the input leaves a result or nothing, never a kind code of three
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser != 2'd3)
    else $error("undefined event kind");

endmodule

bind ber_tlv_header_parser_top btlv_checker u_btlv_checker (.*);

### test/ber_tlv_header_parser_top_test.sv
// ----------------------------------------------------------------------------
// BER TLV header parser testbench
// Drives BER buffers one byte per slave transaction and checks each master
// transaction against a local decoder model or, on typed rows, the scripted
// event. A short scripted part covers every event kind and error code.
// Random buffers follow: mostly well-formed elements, some truncated, some
// with bad lengths, some noise. Four phases idle none, sender, sink, both.
// ----------------------------------------------------------------------------
module ber_tlv_header_parser_top_test;
  import btlv_pkg::*;

  localparam int unsigned CycleLimit  = 200_000;
  localparam int unsigned PhaseBytes  = 138;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned ShownFaults = 10;

  // Decoder walk, one step per accepted byte
  typedef enum logic [2:0] {
    AWAIT_ID, HIGH_TAG, LEN_FIRST, LEN_MORE, IN_CONTENT, DISCARD
  } walk_e;

  // One master transaction, field by field
  typedef struct packed {
    event_kind_e kind;
    logic [1:0]  tag_class;
    logic        constructed;
    logic [63:0] tag_number;
    logic [63:0] content_length;
    logic [7:0]  content_byte;
    logic        last_content;
    error_code_e error_code;
  } tlv_event_t;

  // One scripted byte; typed rows carry their expected event
  typedef struct packed {
    logic [7:0] data;
    logic       eob;
    logic       typed;
    tlv_event_t ev;
  } script_row_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tlast;

  // Decoder model state
  walk_e       walk_state = AWAIT_ID;
  logic [1:0]  hold_class = '0;
  logic        hold_cons  = 1'b0;
  logic [63:0] tag_acc    = '0;
  logic [3:0]  len_left   = '0;
  logic [63:0] len_acc    = '0;
  logic [63:0] bytes_left = '0;

  tlv_event_t  pending_events[$];
  script_row_t script_q[$];
  logic [7:0]  buf_bytes[$];
  logic        row_typed;
  tlv_event_t  row_expect;
  int unsigned send_gap_pct;
  int unsigned sink_stall_pct;
  int unsigned bytes_sent;
  int unsigned fault_count = 0;
  int unsigned cycle_count = 0;

  ber_tlv_header_parser_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------------
  function automatic tlv_event_t fault_ev(error_code_e code);
    tlv_event_t ev;
    ev = '0;
    ev.kind       = EV_ERROR;
    ev.error_code = code;
    return ev;
  endfunction

  function automatic tlv_event_t header_ev(logic [1:0] cls, logic cons,
                                           logic [63:0] tag, logic [63:0] len);
    tlv_event_t ev;
    ev = '0;
    ev.kind           = EV_HEADER;
    ev.tag_class      = cls;
    ev.constructed    = cons;
    ev.tag_number     = tag;
    ev.content_length = len;
    return ev;
  endfunction

  function automatic tlv_event_t content_ev(logic [7:0] data, logic last);
    tlv_event_t ev;
    ev = '0;
    ev.kind         = EV_CONTENT;
    ev.content_byte = data;
    ev.last_content = last;
    return ev;
  endfunction

  // An error on the final byte ends the buffer; otherwise drop to its end
  function automatic tlv_event_t raise_fault(error_code_e code, logic eob);
    walk_state = eob ? AWAIT_ID : DISCARD;
    return fault_ev(code);
  endfunction

  function automatic tlv_event_t close_header(logic [63:0] len, logic eob);
    if (eob && len != 0) return raise_fault(ERR_TRUNCATED, 1'b1);
    if (!hold_cons && len != 0) begin
      bytes_left = len;
      walk_state = IN_CONTENT;
    end else begin
      walk_state = AWAIT_ID;
    end
    return header_ev(hold_class, hold_cons, tag_acc, len);
  endfunction

  // Advance the model by one byte; returns 1 when the byte yields an event
  function automatic bit decode_byte(logic [7:0] b, logic eob, output tlv_event_t ev);
    ev = '0;
    case (walk_state)
      AWAIT_ID: begin
        hold_class = b[7:6];
        hold_cons  = b[5];
        tag_acc    = {59'd0, b[4:0]};
        if (b[4:0] == HighTagMark) begin
          tag_acc    = '0;
          walk_state = HIGH_TAG;
        end else begin
          walk_state = LEN_FIRST;
        end
      end
      HIGH_TAG: begin
        // Older tag bits shift out of the top
        tag_acc = {tag_acc[56:0], b[6:0]};
        if (!b[7]) walk_state = LEN_FIRST;
      end
      LEN_FIRST: begin
        if (!b[7]) begin
          ev = close_header({56'd0, b}, eob);
          return 1'b1;
        end
        if (b[6:0] == 7'd0) begin
          ev = raise_fault(ERR_INDEFINITE, eob);
          return 1'b1;
        end
        if (b[6:0] > MaxLengthBytes) begin
          ev = raise_fault(ERR_LEN_BYTES, eob);
          return 1'b1;
        end
        len_left   = b[3:0];
        len_acc    = '0;
        walk_state = LEN_MORE;
      end
      LEN_MORE: begin
        len_acc  = {len_acc[55:0], b};
        len_left = len_left - 4'd1;
        if (len_left == 4'd0) begin
          ev = close_header(len_acc, eob);
          return 1'b1;
        end
      end
      IN_CONTENT: begin
        if (eob && bytes_left > 1) begin
          ev = raise_fault(ERR_TRUNCATED, 1'b1);
          return 1'b1;
        end
        if (bytes_left <= 1) begin
          ev         = content_ev(b, 1'b1);
          bytes_left = '0;
          walk_state = AWAIT_ID;
        end else begin
          ev         = content_ev(b, 1'b0);
          bytes_left = bytes_left - 1;
        end
        return 1'b1;
      end
      default: begin
        if (eob) walk_state = AWAIT_ID;
        return 1'b0;
      end
    endcase
    // Header still open: the buffer end truncates it
    if (eob) begin
      ev = raise_fault(ERR_TRUNCATED, 1'b1);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  function automatic string describe(tlv_event_t ev);
    return $sformatf("kind=%0d class=%0d cons=%0b tag=%h len=%h data=%h last=%0b err=%0d",
                     ev.kind, ev.tag_class, ev.constructed, ev.tag_number,
                     ev.content_length, ev.content_byte, ev.last_content, ev.error_code);
  endfunction

  function automatic void report_fault(string msg);
    fault_count++;
    if (fault_count <= ShownFaults) $display("%0t: %s", $time, msg);
  endfunction

  function automatic void check_event();
    tlv_event_t got;
    tlv_event_t want;
    got.kind           = event_kind_e'(m_axis_tuser);
    got.tag_class      = m_axis_tdata[1:0];
    got.constructed    = m_axis_tdata[2];
    got.tag_number     = m_axis_tdata[66:3];
    got.content_length = m_axis_tdata[130:67];
    got.content_byte   = m_axis_tdata[138:131];
    got.last_content   = m_axis_tlast;
    got.error_code     = error_code_e'(m_axis_tdata[140:139]);
    if (pending_events.size() == 0) begin
      report_fault({"unexpected event: ", describe(got)});
      return;
    end
    want = pending_events.pop_front();
    if (got.kind !== want.kind || got.tag_class !== want.tag_class ||
        got.constructed !== want.constructed || got.tag_number !== want.tag_number ||
        got.content_length !== want.content_length ||
        got.content_byte !== want.content_byte ||
        got.last_content !== want.last_content || got.error_code !== want.error_code ||
        m_axis_tdata[143:141] !== 3'b000) begin
      report_fault({"event mismatch\n  expected ", describe(want),
                    "\n  actual   ", describe(got),
                    $sformatf(" pad=%b", m_axis_tdata[143:141])});
    end
  endfunction

  // Predict on every slave transaction, check every master transaction
  always @(posedge clk_i) begin : monitor
    tlv_event_t ev;
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("** ber_tlv_header_parser_top: FAILED **");
      $finish;
    end else if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (decode_byte(s_axis_tdata, s_axis_tlast, ev))
          pending_events.insert(pending_events.size(), row_typed ? row_expect : ev);
      end
      if (m_axis_tvalid && m_axis_tready) check_event();
    end
  end

  // ---------------------------------------------------------------------------
  // Master side: stall at random, changed at the falling edge
  // ---------------------------------------------------------------------------
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    forever begin
      @(negedge clk_i);
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Slave side
  // ---------------------------------------------------------------------------
  // Entered and left at a falling edge; valid stays high across back-to-back
  // transactions so it is never lowered and raised in one step
  task automatic send_byte(logic [7:0] b, logic eob, logic typed, tlv_event_t ev);
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eob;
    row_typed     <= typed;
    row_expect    <= ev;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  function automatic void put(logic [7:0] b, logic eob, logic typed = 1'b0,
                              tlv_event_t ev = '0);
    script_q.insert(script_q.size(), '{data: b, eob: eob, typed: typed, ev: ev});
  endfunction

  // Add one byte at the end of the buffer under construction
  function automatic void append_byte(logic [7:0] b);
    buf_bytes.insert(buf_bytes.size(), b);
  endfunction

  // Append one element: identifier, length and, for a primitive, its content
  function automatic void add_element();
    logic        cons;
    logic [1:0]  cls;
    logic [7:0]  fill;
    int unsigned n_tag;
    int unsigned n_len;
    int unsigned len;
    cons = ($urandom_range(3) == 0);
    cls  = 2'($urandom_range(3));
    if ($urandom_range(3) == 0) begin
      // High tag form; long runs push bits out of the 64-bit tag
      append_byte({cls, cons, HighTagMark});
      n_tag = ($urandom_range(5) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 3);
      for (int i = 1; i < n_tag; i++) append_byte({1'b1, 7'($urandom)});
      append_byte({1'b0, 7'($urandom)});
    end else begin
      append_byte({cls, cons, 5'($urandom_range(30))});
    end
    if (cons) begin
      if ($urandom_range(2) == 0) begin
        // Wide lengths only where no content follows
        n_len = $urandom_range(1) ? 8 : $urandom_range(1, 7);
        fill  = $urandom_range(1) ? 8'hFF : 8'h00;
        append_byte(8'h80 | 8'(n_len));
        for (int i = 0; i < n_len; i++)
          append_byte(fill == 8'hFF ? fill : 8'($urandom));
      end else begin
        append_byte(8'($urandom_range(127)));
      end
      return;
    end
    len = ($urandom_range(4) == 0) ? 0 : $urandom_range(1, 6);
    if ($urandom_range(2) == 0) begin
      // Long form with leading zero bytes
      n_len = $urandom_range(1, 8);
      append_byte(8'h80 | 8'(n_len));
      for (int i = 1; i < n_len; i++) append_byte(8'h00);
    end
    append_byte(8'(len));
    for (int i = 0; i < len; i++) append_byte(8'($urandom));
  endfunction

  function automatic void compose_buffer();
    int unsigned pick;
    int unsigned keep;
    buf_bytes.delete();
    pick = $urandom_range(99);
    if (pick < 75) begin
      repeat ($urandom_range(1, 4)) add_element();
    end else if (pick < 85) begin
      // Cut short anywhere
      repeat ($urandom_range(1, 3)) add_element();
      keep = $urandom_range(1, buf_bytes.size());
      while (buf_bytes.size() > keep) void'(buf_bytes.pop_back());
    end else if (pick < 93) begin
      // Bad length byte on a fresh header, then junk to drop
      if ($urandom_range(1)) add_element();
      append_byte({2'($urandom_range(3)), 1'($urandom), 5'($urandom_range(30))});
      append_byte($urandom_range(1) ? 8'h80 : 8'h80 | 8'($urandom_range(9, 127)));
      repeat ($urandom_range(0, 5)) append_byte(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 10)) append_byte(8'($urandom));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned gap_pct[4];
    int unsigned stall_pct[4];
    gap_pct   = '{0, 65, 0, 28};
    stall_pct = '{0, 0, 65, 28};
    send_gap_pct   = 0;
    sink_stall_pct = 0;
    bytes_sent     = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    row_typed     <= 1'b0;
    row_expect    <= '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Primitive with empty content, straight after reset
    put(8'h02, 1'b0);
    put(8'h00, 1'b0, 1'b1, header_ev(2'd0, 1'b0, 64'd2, 64'd0));
    // Private constructed, high tag over two bytes, all-ones identifier
    put(8'hFF, 1'b0);
    put(8'hFF, 1'b0);
    put(8'h7F, 1'b0);
    put(8'h00, 1'b0, 1'b1, header_ev(2'd3, 1'b1, 64'h3FFF, 64'd0));
    // Indefinite length, then drop to the buffer end
    put(8'h1F, 1'b0);
    put(8'h00, 1'b0);
    put(8'h80, 1'b0, 1'b1, fault_ev(ERR_INDEFINITE));
    put(8'h55, 1'b1);
    // Nine length bytes
    put(8'h04, 1'b0);
    put(8'h89, 1'b0, 1'b1, fault_ev(ERR_LEN_BYTES));
    put(8'h00, 1'b1);
    // Long-form length of two; last content byte is the final buffer byte
    put(8'h44, 1'b0);
    put(8'h82, 1'b0);
    put(8'h00, 1'b0);
    put(8'h02, 1'b0, 1'b1, header_ev(2'd1, 1'b0, 64'd4, 64'd2));
    put(8'hAA, 1'b0, 1'b1, content_ev(8'hAA, 1'b0));
    put(8'hBB, 1'b1, 1'b1, content_ev(8'hBB, 1'b1));
    // Identifier alone at the buffer end
    put(8'h30, 1'b1, 1'b1, fault_ev(ERR_TRUNCATED));
    // Header closes on the final byte with content still owed
    put(8'h04, 1'b0);
    put(8'h05, 1'b1, 1'b1, fault_ev(ERR_TRUNCATED));
    // Content cut short by the buffer end
    put(8'h04, 1'b0);
    put(8'h02, 1'b0, 1'b1, header_ev(2'd0, 1'b0, 64'd4, 64'd2));
    put(8'h11, 1'b1, 1'b1, fault_ev(ERR_TRUNCATED));

    foreach (script_q[i])
      send_byte(script_q[i].data, script_q[i].eob, script_q[i].typed, script_q[i].ev);

    // Random buffers under each idling mix; the buffer end always closes a phase
    for (int p = 0; p < 4; p++) begin
      send_gap_pct   = gap_pct[p];
      sink_stall_pct = stall_pct[p];
      bytes_sent     = 0;
      while (bytes_sent < PhaseBytes) begin
        compose_buffer();
        foreach (buf_bytes[i])
          send_byte(buf_bytes[i], (i == buf_bytes.size() - 1), 1'b0, '0);
      end
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then hold a little longer to catch stray events
    while (pending_events.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (pending_events.size() != 0)
      report_fault($sformatf("%0d expected events never arrived", pending_events.size()));

    if (fault_count == 0) begin
      $display("** ber_tlv_header_parser_top: PASSED **");
    end else begin
      $display("** ber_tlv_header_parser_top: FAILED **");
    end
    $finish;
  end

endmodule
